FILE: design/acpi_pkg.sv
package acpi_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_W    = 16;
    localparam int GAIN_W    = 24;
    localparam int GAIN_FRAC = 12;
    localparam int HDG_IN_W  = 26;
    localparam int HDG_OUT_W = 25;
    localparam int THR_W     = 23;
    localparam int N_CFG     = 8;
    localparam int CFG_IDX_W = $clog2(N_CFG);
    localparam int A_W       = DATA_W + 1;
    localparam int P_W       = A_W + GAIN_W + 1;
    localparam int ACC_W     = 48;
    localparam int STEP_W    = 4;

    localparam longint ONE_L      = 64'sd1 <<< FRAC_W;
    localparam longint DATA_MAX_L = (64'sd1 <<< (DATA_W - 1)) - 64'sd1;
    localparam longint DATA_MIN_L = -DATA_MAX_L - 64'sd1;

    localparam logic [GAIN_W-1:0] DT_NUM = GAIN_W'(((64'sd1 <<< FRAC_W) + 64'sd50) / 64'sd100);

    localparam logic signed [ACC_W-1:0] ONE_A      = ACC_W'(ONE_L);
    localparam logic signed [ACC_W-1:0] HALF_A     = ACC_W'(ONE_L >>> 1);
    localparam logic signed [ACC_W-1:0] ZERO_A     = '0;
    localparam logic signed [ACC_W-1:0] THR_MAX_A  = ACC_W'(64'sd90 * ONE_L);
    localparam logic signed [ACC_W-1:0] DATA_MAX_A = ACC_W'(DATA_MAX_L);
    localparam logic signed [ACC_W-1:0] DATA_MIN_A = ACC_W'(DATA_MIN_L);

    localparam logic [THR_W-1:0] THR_RESET = THR_W'((64'sd3623 * ONE_L + 64'sd50) / 64'sd100);

    localparam logic signed [HDG_IN_W:0] DEG180 = (HDG_IN_W + 1)'(64'sd180 * ONE_L);
    localparam logic signed [HDG_IN_W:0] DEG360 = (HDG_IN_W + 1)'(64'sd360 * ONE_L);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEIGHT_P = 3'd0,
        CFG_HEIGHT_I = 3'd1,
        CFG_PITCH_P  = 3'd2,
        CFG_PITCH_I  = 3'd3,
        CFG_ROLL_P   = 3'd4,
        CFG_ROLL_I   = 3'd5,
        CFG_SPEED_P  = 3'd6,
        CFG_SPEED_I  = 3'd7
    } t_cfg_reg;

    localparam logic [GAIN_W-1:0] GAIN_RESET [N_CFG] = '{
        24'd3277, 24'd410, 24'd2048, 24'd205, 24'd6554, 24'd0, 24'd4096000, 24'd6144000
    };

    typedef enum logic [STEP_W-1:0] {
        ST_H_DT = 4'd0,
        ST_H_P  = 4'd1,
        ST_H_I  = 4'd2,
        ST_P_DT = 4'd3,
        ST_P_P  = 4'd4,
        ST_P_I  = 4'd5,
        ST_R_DT = 4'd6,
        ST_R_P  = 4'd7,
        ST_R_I  = 4'd8,
        ST_S_DT = 4'd9,
        ST_S_P  = 4'd10,
        ST_S_I  = 4'd11
    } t_step;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_MUL  = 2'd1,
        S_ACC  = 2'd2,
        S_FIN  = 2'd3
    } t_state;

    typedef struct packed {
        logic  idle;
        logic  start;
        logic  mul_en;
        logic  acc_en;
        logic  fin;
        t_step step;
    } t_ctrl;

    function automatic logic signed [ACC_W-1:0] clamp_acc(
        input logic signed [ACC_W-1:0] v,
        input logic signed [ACC_W-1:0] lo,
        input logic signed [ACC_W-1:0] hi
    );
        logic signed [ACC_W-1:0] r;
        r = v;
        if (v > hi) begin
            r = hi;
        end else if (v < lo) begin
            r = lo;
        end
        return r;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] c;
        c = clamp_acc(v, DATA_MIN_A, DATA_MAX_A);
        return c[DATA_W-1:0];
    endfunction

endpackage

FILE: design/acpi_mul.sv
module acpi_mul import acpi_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [A_W-1:0]   i_a,
    input  logic [GAIN_W-1:0]       i_b,
    input  logic                    i_fine,
    output logic signed [ACC_W-1:0] o_rnd
);

    logic signed [P_W-1:0] r_prod;
    logic                  r_fine;
    logic signed [P_W-1:0] w_sum;
    logic signed [P_W-1:0] w_shr;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= P_W'(i_a * $signed({1'b0, i_b}));
            r_fine <= i_fine;
        end
    end

    // round half up, then drop the fraction of the multiplier operand
    always_comb begin
        if (r_fine) begin
            w_sum = r_prod + (P_W'(1) <<< (FRAC_W - 1));
            w_shr = w_sum >>> FRAC_W;
        end else begin
            w_sum = r_prod + (P_W'(1) <<< (GAIN_FRAC - 1));
            w_shr = w_sum >>> GAIN_FRAC;
        end
    end

    assign o_rnd = w_shr[ACC_W-1:0];

endmodule

FILE: design/acpi_seq.sv
module acpi_seq import acpi_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_out_free,
    output t_ctrl o_ctrl
);

    t_state r_state, n_state;
    t_step  r_step, n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= ST_H_DT;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_step        = r_step;
        o_ctrl        = '0;
        o_ctrl.step   = r_step;
        unique case (r_state)
            S_IDLE: begin
                o_ctrl.idle = 1'b1;
                if (i_in_valid) begin
                    o_ctrl.start = 1'b1;
                    n_step       = ST_H_DT;
                    n_state      = S_MUL;
                end
            end
            S_MUL: begin
                o_ctrl.mul_en = 1'b1;
                n_state       = S_ACC;
            end
            S_ACC: begin
                o_ctrl.acc_en = 1'b1;
                if (r_step == ST_S_I) begin
                    n_state = S_FIN;
                end else begin
                    n_step  = t_step'(r_step + STEP_W'(1));
                    n_state = S_MUL;
                end
            end
            S_FIN: begin
                if (i_out_free) begin
                    o_ctrl.fin = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: design/cascaded_pi_autopilot_step.sv
// an accepted transaction registers its input errors; o_in_stall then holds off the next
// one until the result is registered on the output; twelve products go through one shared
// multiplier, each passing through a multiply state and a round/accumulate state;
// the next transaction is accepted while the previous result waits on the output
// reset: synchronous, active low; gains to defaults, integrators and last speed
// error to zero, throttle to 36.23 percent, no result pending
module cascaded_pi_autopilot_step import acpi_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic signed [DATA_W-1:0]    i_height_target,
    input  logic signed [DATA_W-1:0]    i_height_measured,
    input  logic signed [DATA_W-1:0]    i_pitch_target,
    input  logic signed [DATA_W-1:0]    i_pitch_measured,
    input  logic signed [DATA_W-1:0]    i_bank_target,
    input  logic signed [DATA_W-1:0]    i_bank_measured,
    input  logic signed [HDG_IN_W-1:0]  i_heading_measured,
    input  logic signed [DATA_W-1:0]    i_speed_target,
    input  logic signed [DATA_W-1:0]    i_speed_measured,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic signed [DATA_W-1:0]    o_elevator_drive,
    output logic signed [DATA_W-1:0]    o_aileron_drive,
    output logic [THR_W-1:0]            o_throttle_drive,
    output logic signed [HDG_OUT_W-1:0] o_heading_wrapped,
    output logic signed [DATA_W-1:0]    o_pitch_correction,
    input  logic                        i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]        i_cfg_addr,
    input  logic [GAIN_W-1:0]           i_cfg_wdata
);

    t_ctrl w_ctrl;
    logic  w_out_free;

    logic [GAIN_W-1:0] r_gain [N_CFG];

    logic signed [DATA_W-1:0] r_hint, r_pint, r_rint, r_lse;
    logic [THR_W-1:0]         r_thr;

    logic signed [DATA_W-1:0]    r_he, r_re, r_se, r_sdt;
    logic signed [A_W-1:0]       r_pdiff;
    logic signed [HDG_OUT_W-1:0] r_hdg;
    logic signed [ACC_W-1:0]     r_acc;
    logic signed [DATA_W-1:0]    r_hout, r_elev, r_ail;
    logic                        r_out_valid;

    logic signed [A_W-1:0]       w_hdiff, w_bdiff, w_sdiff, w_pdiff;
    logic signed [HDG_IN_W:0]    w_hdg;
    logic signed [DATA_W-1:0]    w_pe;
    logic signed [A_W-1:0]       w_a;
    logic [GAIN_W-1:0]           w_b;
    logic                        w_fine;
    logic signed [ACC_W-1:0]     w_rnd;
    logic signed [ACC_W-1:0]     w_sum;
    logic signed [DATA_W-1:0]    w_du;
    logic signed [ACC_W-1:0]     w_thr;

    acpi_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_free (w_out_free),
        .o_ctrl     (w_ctrl)
    );

    acpi_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (w_ctrl.mul_en),
        .i_a    (w_a),
        .i_b    (w_b),
        .i_fine (w_fine),
        .o_rnd  (w_rnd)
    );

    assign o_in_stall = !w_ctrl.idle;
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < N_CFG; k++) begin
                r_gain[k] <= GAIN_RESET[k];
            end
        end else if (i_cfg_wr_en) begin
            r_gain[i_cfg_addr] <= i_cfg_wdata;
        end
    end

    // input differences, heading wrap
    always_comb begin
        w_hdiff = A_W'(i_height_target) - A_W'(i_height_measured);
        w_bdiff = A_W'(i_bank_target) - A_W'(i_bank_measured);
        w_sdiff = A_W'(i_speed_target) - A_W'(i_speed_measured);
        w_pdiff = A_W'(i_pitch_target) - A_W'(i_pitch_measured);
        w_hdg   = (HDG_IN_W + 1)'(i_heading_measured);
        if (w_hdg > DEG180) begin
            w_hdg = w_hdg - DEG360;
        end else if (w_hdg < -DEG180) begin
            w_hdg = w_hdg + DEG360;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.start) begin
            r_he    <= DATA_W'(clamp_acc(ACC_W'(w_hdiff), -HALF_A, HALF_A));
            r_re    <= sat_data(ACC_W'(w_bdiff));
            r_se    <= sat_data(ACC_W'(w_sdiff));
            r_pdiff <= w_pdiff;
            r_hdg   <= w_hdg[HDG_OUT_W-1:0];
        end
    end

    assign w_pe = sat_data(ACC_W'(r_pdiff) + ACC_W'(r_hout));

    // operand select for the shared multiplier
    always_comb begin
        w_a    = A_W'(r_he);
        w_b    = DT_NUM;
        w_fine = 1'b1;
        unique case (w_ctrl.step)
            ST_H_DT: begin
                w_a = A_W'(r_he);
            end
            ST_H_P: begin
                w_a    = A_W'(r_he);
                w_b    = r_gain[CFG_HEIGHT_P];
                w_fine = 1'b0;
            end
            ST_H_I: begin
                w_a    = A_W'(r_hint);
                w_b    = r_gain[CFG_HEIGHT_I];
                w_fine = 1'b0;
            end
            ST_P_DT: begin
                w_a = A_W'(w_pe);
            end
            ST_P_P: begin
                w_a    = A_W'(w_pe);
                w_b    = r_gain[CFG_PITCH_P];
                w_fine = 1'b0;
            end
            ST_P_I: begin
                w_a    = A_W'(r_pint);
                w_b    = r_gain[CFG_PITCH_I];
                w_fine = 1'b0;
            end
            ST_R_DT: begin
                w_a = A_W'(r_re);
            end
            ST_R_P: begin
                w_a    = A_W'(r_re);
                w_b    = r_gain[CFG_ROLL_P];
                w_fine = 1'b0;
            end
            ST_R_I: begin
                w_a    = A_W'(r_rint);
                w_b    = r_gain[CFG_ROLL_I];
                w_fine = 1'b0;
            end
            ST_S_DT: begin
                w_a = A_W'(r_se);
            end
            ST_S_P: begin
                w_a    = A_W'(r_se) - A_W'(r_lse);
                w_b    = r_gain[CFG_SPEED_P];
                w_fine = 1'b0;
            end
            ST_S_I: begin
                w_a    = A_W'(r_sdt);
                w_b    = r_gain[CFG_SPEED_I];
                w_fine = 1'b0;
            end
            default: begin
                w_a = A_W'(r_he);
            end
        endcase
    end

    assign w_sum = r_acc + w_rnd;
    assign w_du  = sat_data(w_sum);
    assign w_thr = clamp_acc(ACC_W'($signed({1'b0, r_thr})) + ACC_W'(w_du), ZERO_A, THR_MAX_A);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hint <= '0;
            r_pint <= '0;
            r_rint <= '0;
            r_lse  <= '0;
            r_thr  <= THR_RESET;
        end else if (w_ctrl.acc_en) begin
            case (w_ctrl.step)
                ST_H_DT: begin
                    r_hint <= DATA_W'(clamp_acc(ACC_W'(r_hint) + w_rnd, -HALF_A, HALF_A));
                end
                ST_P_DT: begin
                    r_pint <= DATA_W'(clamp_acc(ACC_W'(r_pint) + w_rnd, -ONE_A, ONE_A));
                end
                ST_R_DT: begin
                    r_rint <= DATA_W'(clamp_acc(ACC_W'(r_rint) + w_rnd, -ONE_A, ONE_A));
                end
                ST_S_I: begin
                    r_thr <= w_thr[THR_W-1:0];
                    r_lse <= r_se;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.acc_en) begin
            case (w_ctrl.step) inside
                ST_H_P, ST_P_P, ST_R_P, ST_S_P: r_acc <= w_rnd;
                ST_H_I:  r_hout <= w_du;
                ST_P_I:  r_elev <= w_du;
                ST_R_I:  r_ail  <= w_du;
                ST_S_DT: r_sdt  <= w_rnd[DATA_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctrl.fin) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.fin) begin
            o_elevator_drive   <= r_elev;
            o_aileron_drive    <= r_ail;
            o_throttle_drive   <= r_thr;
            o_heading_wrapped  <= r_hdg;
            o_pitch_correction <= r_hout;
        end
    end

    assign o_out_valid = r_out_valid;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("block took a second transaction right after accepting one");

    a_height_int_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ACC_W'(r_hint) <= HALF_A && ACC_W'(r_hint) >= -HALF_A)
        else $error("height integrator outside its clamp");

    a_pitch_int_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ACC_W'(r_pint) <= ONE_A && ACC_W'(r_pint) >= -ONE_A)
        else $error("pitch integrator outside its clamp");

    a_throttle_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ACC_W'($signed({1'b0, r_thr})) <= THR_MAX_A)
        else $error("throttle level above its limit");

endmodule
